### src/bafd_pkg.sv
// Shared types, constants and helpers for the bridge ADC frame decoder.
package bafd_pkg;

    localparam int FRAME_W     = 28;
    localparam int SAMPLE_BITS = 24;
    localparam int PROBE_W     = 24;
    localparam int WORD_W      = 32;
    localparam int CODE_W      = 3;
    localparam int PULSE_W     = 5;
    localparam int PERIOD_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int MAX_TAIL    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_A_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_B_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd4;

    // error state codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DESYNC  = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    localparam logic [CODE_W-1:0]   CODE_MIN      = 3'd1;
    localparam logic [CODE_W-1:0]   CODE_MAX      = 3'd4;
    localparam logic [CODE_W-1:0]   RST_LEGACY    = 3'd1;
    localparam logic [CODE_W-1:0]   RST_CHAN_A    = 3'd1;
    localparam logic [CODE_W-1:0]   RST_CHAN_B    = 3'd4;
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = 8'd13;
    localparam logic [1:0]          SETTLE_RESET  = 2'd2;

    localparam logic [WORD_W-1:0] WORD_DESYNC  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_OVERRUN = 32'h4000_0000;
    localparam int TAG_CHAN_B_BIT = 24;
    localparam int TAG_STALE_BIT  = 25;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_bits;
        logic               read_overrun;
    } t_in;

    typedef struct packed {
        logic [PULSE_W-1:0]        pulse_count;
        logic [WORD_W-1:0]         report_word;
        logic signed [PROBE_W-1:0] probe_value;
        logic                      probe_valid;
    } t_out;

    // per-request schedule decision
    typedef struct packed {
        logic              il;
        logic              chan_b;
        logic              stale;
        logic [CODE_W-1:0] code;
    } t_sched;

    function automatic logic [CODE_W-1:0] clamp_code(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] r;
        r = c;
        if (c < CODE_MIN) r = CODE_MIN;
        else if (c > CODE_MAX) r = CODE_MAX;
        return r;
    endfunction

endpackage

### src/bafd_sched.sv
// Config registers, A/B interleave schedule and sticky error state.
module bafd_sched (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bafd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bafd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_step,
    input  logic [1:0]                      i_err_next,
    output bafd_pkg::t_sched                o_sched,
    output logic [1:0]                      o_err
);
    import bafd_pkg::*;

    logic [CODE_W-1:0]   r_legacy;
    logic                r_il;
    logic [CODE_W-1:0]   r_code_a;
    logic [CODE_W-1:0]   r_code_b;
    logic [PERIOD_W-1:0] r_period;
    logic [1:0]          r_err;
    logic [PERIOD_W-1:0] r_cnt;
    logic                r_chan;
    logic [1:0]          r_settle;

    logic [PERIOD_W-1:0] w_cnt_inc;
    logic [PERIOD_W-1:0] n_cnt;
    logic                n_chan;
    logic [1:0]          n_settle;
    logic                w_stale;

    always_comb begin
        n_settle = r_settle;
        w_stale  = 1'b0;
        if (r_chan) begin
            n_settle = SETTLE_RESET;
        end else if (r_settle != 2'd0) begin
            w_stale  = 1'b1;
            n_settle = r_settle - 2'd1;
        end
        w_cnt_inc = r_cnt + 8'd1;
        if (w_cnt_inc >= r_period) begin
            n_cnt  = '0;
            n_chan = 1'b1;
        end else begin
            n_cnt  = w_cnt_inc;
            n_chan = 1'b0;
        end
    end

    always_comb begin
        o_sched.il     = r_il;
        o_sched.chan_b = r_il & r_chan;
        o_sched.stale  = r_il & w_stale;
        o_sched.code   = r_il ? clamp_code(n_chan ? r_code_b : r_code_a)
                              : clamp_code(r_legacy);
    end

    assign o_err = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legacy <= RST_LEGACY;
            r_il     <= 1'b0;
            r_code_a <= RST_CHAN_A;
            r_code_b <= RST_CHAN_B;
            r_period <= RST_PERIOD;
            r_err    <= ERR_NONE;
            r_cnt    <= '0;
            r_chan   <= 1'b0;
            r_settle <= SETTLE_RESET;
        end else begin
            if (i_step) begin
                r_err <= i_err_next;
                if (r_il) begin
                    r_cnt    <= n_cnt;
                    r_chan   <= n_chan;
                    r_settle <= n_settle;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LEGACY_GAIN: begin
                        r_legacy <= i_cfg_data[CODE_W-1:0];
                        r_err    <= ERR_NONE;
                    end
                    CFG_INTERLEAVE: begin
                        r_il <= i_cfg_data[0];
                        if (i_cfg_data[0]) begin
                            r_cnt    <= '0;
                            r_chan   <= 1'b0;
                            r_settle <= SETTLE_RESET;
                        end
                    end
                    CFG_CHAN_A_CODE: r_code_a <= i_cfg_data[CODE_W-1:0];
                    CFG_CHAN_B_CODE: r_code_b <= i_cfg_data[CODE_W-1:0];
                    CFG_PERIOD:      r_period <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### src/bafd_decode.sv
// Frame decode: count extraction, trailing-bit check and result formatting.
module bafd_decode (
    input  bafd_pkg::t_in    i_req,
    input  bafd_pkg::t_sched i_sched,
    input  logic [1:0]       i_err,
    output logic [1:0]       o_err_next,
    output bafd_pkg::t_out   o_res
);
    import bafd_pkg::*;

    localparam int LSB = FRAME_W - SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] w_count;
    logic signed [PROBE_W-1:0]     w_count_p;
    logic signed [WORD_W-1:0]      w_count_w;
    logic                          w_desync;
    logic [WORD_W-1:0]             w_word;

    always_comb begin
        w_count   = i_req.frame_bits[FRAME_W-1 -: SAMPLE_BITS];
        w_count_p = PROBE_W'(w_count);
        w_count_w = WORD_W'(w_count);

        // trailing pulses after the count must all read high
        w_desync = 1'b0;
        for (int j = 0; j < MAX_TAIL; j++) begin
            if ((j < int'(i_sched.code)) && !i_req.frame_bits[LSB-1-j]) w_desync = 1'b1;
        end

        if (w_desync) o_err_next = ERR_DESYNC;
        else if (i_req.read_overrun) o_err_next = ERR_OVERRUN;
        else o_err_next = i_err;

        if (o_err_next == ERR_DESYNC) begin
            w_word = WORD_DESYNC;
        end else if (o_err_next != ERR_NONE) begin
            w_word = WORD_OVERRUN;
        end else if (i_sched.il) begin
            w_word = {{(WORD_W-PROBE_W){1'b0}}, w_count_p};
            w_word[TAG_CHAN_B_BIT] = i_sched.chan_b;
            w_word[TAG_STALE_BIT]  = i_sched.stale;
        end else begin
            w_word = w_count_w;
        end

        o_res.pulse_count = PULSE_W'(SAMPLE_BITS) + PULSE_W'(i_sched.code);
        o_res.report_word = w_word;
        o_res.probe_value = w_count_p;
        o_res.probe_valid = (o_err_next == ERR_NONE) && !i_sched.chan_b;
    end

endmodule

### src/bridge_adc_frame_decoder.sv
// Bridge ADC frame decoder: one conversion frame in, one report out, with
// optional A/B interleave. A request is registered on entry, decoded in a
// single pass against the schedule and error state, and the result held in
// an output register; output valid rises when the request moves from the input
// register into the output register, and one request is taken every cycle
// while the output keeps moving.
// The schedule and sticky error advance when a request moves into the
// output register, so throughput is set only by output stall. Config writes
// are expected while no request is in flight.
module bridge_adc_frame_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bafd_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bafd_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [bafd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bafd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bafd_pkg::*;

    logic   r_in_valid;
    t_in    r_in;
    logic   r_out_valid;
    t_out   r_out;

    logic   w_out_ready;
    logic   w_step;
    t_sched w_sched;
    logic [1:0] w_err;
    logic [1:0] n_err;
    t_out   n_out;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    bafd_sched u_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_step),
        .i_err_next (n_err),
        .o_sched    (w_sched),
        .o_err      (w_err)
    );

    bafd_decode u_decode (
        .i_req      (r_in),
        .i_sched    (w_sched),
        .i_err      (w_err),
        .o_err_next (n_err),
        .o_res      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (w_out_ready) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in <= i_in;
        if (w_step) r_out <= n_out;
    end

endmodule

### src/bafd_checker.sv
// Port-level checks for the bridge ADC frame decoder, bound to the top level.
module bafd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input bafd_pkg::t_out o_out
);
    import bafd_pkg::*;

    localparam logic [PULSE_W-1:0] PULSE_LO = PULSE_W'(SAMPLE_BITS) + PULSE_W'(CODE_MIN);
    localparam logic [PULSE_W-1:0] PULSE_HI = PULSE_W'(SAMPLE_BITS) + PULSE_W'(CODE_MAX);

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.pulse_count >= PULSE_LO) && (o_out.pulse_count <= PULSE_HI))
        else $error("pulse count out of range");

    // a sign-extended count has equal top bits; differing top two bits mark an error word
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.report_word[31] != o_out.report_word[30]))
            |-> ((o_out.report_word[29:0] == '0) && !o_out.probe_valid))
        else $error("error report carries data");

    a_probe_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.report_word[31:30] == 2'b00)
            |-> (o_out.report_word[PROBE_W-1:0] == o_out.probe_value))
        else $error("report count differs from probe value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind bridge_adc_frame_decoder bafd_checker u_bafd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

### test/tb_bridge_adc_frame_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bridge ADC frame decoder, random and directed frames.
module tb_bridge_adc_frame_decoder;
    import bafd_pkg::*;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  in_valid = 1'b0;
    t_in                   in_req   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out                  out_rsp;

    bridge_adc_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // decoder state as the testbench tracks it
    logic [CODE_W-1:0]   legacy_code;
    logic [CODE_W-1:0]   a_code;
    logic [CODE_W-1:0]   b_code;
    logic [PERIOD_W-1:0] il_period;
    logic                il_on;
    logic [1:0]          err_held;
    logic [PERIOD_W-1:0] sched_cnt;
    logic                data_b;
    logic [1:0]          settle_cnt;

    t_in  pending_frames[$];
    t_out expected_reports[$];
    int   mismatches = 0;
    int   in_wait    = 0;
    int   out_wait   = 0;
    logic in_calm    = 1'b0;
    logic out_calm   = 1'b0;
    logic noisy      = 1'b0;
    int   rand_sent  = 0;
    int   phase_len  = 0;

    function automatic logic [CODE_W-1:0] bound_code(input logic [CODE_W-1:0] c);
        if (c < CODE_MIN) return CODE_MIN;
        if (c > CODE_MAX) return CODE_MAX;
        return c;
    endfunction

    function automatic t_out decode_frame(input t_in req);
        t_out                   rsp;
        logic                   this_b;
        logic                   next_b;
        logic                   stale;
        logic                   good;
        logic [CODE_W-1:0]      code;
        logic [PULSE_W-1:0]     pulses;
        logic [FRAME_W-1:0]     raw;
        logic [SAMPLE_BITS-1:0] count;
        logic [MAX_TAIL-1:0]    tail;
        this_b = 1'b0;
        stale  = 1'b0;
        if (il_on) begin
            this_b = data_b;
            next_b = 1'b0;
            if (this_b) begin
                settle_cnt = SETTLE_RESET;
            end else if (settle_cnt != 0) begin
                stale      = 1'b1;
                settle_cnt = settle_cnt - 1'b1;
            end
            sched_cnt = sched_cnt + 1'b1;
            if (sched_cnt >= il_period) begin
                sched_cnt = '0;
                next_b    = 1'b1;
            end
            code   = bound_code(next_b ? b_code : a_code);
            data_b = next_b;
        end else begin
            code = bound_code(legacy_code);
        end
        pulses = PULSE_W'(SAMPLE_BITS) + code;
        raw    = req.frame_bits >> (FRAME_W - pulses);
        count  = SAMPLE_BITS'(raw >> code);
        tail   = MAX_TAIL'((1 << code) - 1);
        good   = ((MAX_TAIL'(raw) & tail) == tail);
        if (!good) err_held = ERR_DESYNC;
        else if (req.read_overrun) err_held = ERR_OVERRUN;

        rsp.pulse_count = pulses;
        rsp.probe_value = count;
        rsp.probe_valid = 1'b0;
        if (err_held == ERR_DESYNC) begin
            rsp.report_word = WORD_DESYNC;
        end else if (err_held != ERR_NONE) begin
            rsp.report_word = WORD_OVERRUN;
        end else begin
            rsp.probe_valid = !il_on || !this_b;
            if (il_on)
                rsp.report_word = {6'd0, stale, this_b, count};
            else
                rsp.report_word = {{(WORD_W - SAMPLE_BITS){count[SAMPLE_BITS-1]}}, count};
        end
        return rsp;
    endfunction

    function automatic int draw_wait(input logic calm);
        return calm ? 0 : $urandom_range(14, 0);
    endfunction

    task automatic check_report(input t_out got);
        t_out want;
        if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected report: pulses %0d word %08h probe %06h valid %0b",
                         got.pulse_count, got.report_word, got.probe_value, got.probe_valid);
        end else begin
            want = expected_reports.pop_front();
            if (got.pulse_count !== want.pulse_count || got.report_word !== want.report_word ||
                got.probe_value !== want.probe_value || got.probe_valid !== want.probe_valid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp pulses %0d word %08h probe %06h valid %0b, %s%0d %08h %06h %0b",
                             want.pulse_count, want.report_word, want.probe_value,
                             want.probe_valid, "got ", got.pulse_count, got.report_word,
                             got.probe_value, got.probe_valid);
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_wait = 0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_reports.push_back(decode_frame(in_req));
                in_wait = draw_wait(in_calm);
            end
            if (!in_valid || !in_stall) begin
                if (in_wait != 0) begin
                    in_wait = in_wait - 1;
                    in_valid <= 1'b0;
                end else if (pending_frames.size() != 0) begin
                    in_req   <= pending_frames.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // report monitor and output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            out_wait = 0;
        end else begin
            if (out_valid && !out_stall) begin
                check_report(out_rsp);
                out_wait = draw_wait(out_calm);
            end
            if (out_wait != 0) begin
                out_wait = out_wait - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_LEGACY_GAIN: begin
                legacy_code = val[CODE_W-1:0];
                err_held    = ERR_NONE;
            end
            CFG_INTERLEAVE: begin
                il_on = val[0];
                if (val[0]) begin
                    sched_cnt  = '0;
                    data_b     = 1'b0;
                    settle_cnt = SETTLE_RESET;
                end
            end
            CFG_CHAN_A_CODE: a_code = val[CODE_W-1:0];
            CFG_CHAN_B_CODE: b_code = val[CODE_W-1:0];
            CFG_PERIOD:      il_period = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // sampled on the falling edge so the driver's queue pops have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_frames.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_frame(input logic [SAMPLE_BITS-1:0] count,
                               input logic [MAX_TAIL-1:0] tail, input logic ovr);
        t_in req;
        req.frame_bits   = {count, tail};
        req.read_overrun = ovr;
        pending_frames.push_back(req);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] random_count();
        case ($urandom_range(15, 0))
            0:       return 24'h000000;
            1:       return 24'h7FFFFF;
            2:       return 24'h800000;
            3:       return 24'hFFFFFF;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // mostly ones on the checked tail bits, random past them (all ones under interleave)
    function automatic logic [MAX_TAIL-1:0] random_tail();
        logic [MAX_TAIL-1:0] keep;
        if (noisy && $urandom_range(9, 0) == 0) return MAX_TAIL'($urandom);
        if (il_on) return {MAX_TAIL{1'b1}};
        keep = MAX_TAIL'({MAX_TAIL{1'b1}} << (MAX_TAIL - bound_code(legacy_code)));
        return keep | MAX_TAIL'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_code_val();
        int r;
        r = $urandom_range(9, 0);
        if (r < 7) return CFG_DATA_W'($urandom_range(CODE_MAX, CODE_MIN));
        if (r < 9) return CFG_DATA_W'($urandom_range(7, 0));
        return CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_period();
        case ($urandom_range(7, 0))
            0:       return 8'd2;
            1:       return 8'd255;
            2:       return CFG_DATA_W'($urandom_range(1, 0));
            3:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(6, 2));
        endcase
    endfunction

    initial begin
        legacy_code = RST_LEGACY;
        a_code      = RST_CHAN_A;
        b_code      = RST_CHAN_B;
        il_period   = RST_PERIOD;
        il_on       = 1'b0;
        err_held    = ERR_NONE;
        sched_cnt   = '0;
        data_b      = 1'b0;
        settle_cnt  = SETTLE_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, extremes of the count
        queue_frame(24'h000000, 4'hF, 1'b0);
        queue_frame(24'h7FFFFF, 4'h8, 1'b0);
        queue_frame(24'h800000, 4'hF, 1'b0);
        wait_idle();
        // out-of-range codes are bounded
        write_reg(CFG_LEGACY_GAIN, 8'd0);
        @(negedge i_clk);
        queue_frame(24'hFFFFFF, 4'hB, 1'b0);
        wait_idle();
        write_reg(CFG_LEGACY_GAIN, 8'd7);
        @(negedge i_clk);
        queue_frame(24'h123456, 4'hF, 1'b0);
        wait_idle();
        write_reg(CFG_LEGACY_GAIN, 8'd3);
        @(negedge i_clk);
        queue_frame(24'hA5A5A5, 4'hE, 1'b0);
        wait_idle();
        // desync, overrun replacing a held desync, sticky overrun, desync beating overrun
        write_reg(CFG_LEGACY_GAIN, 8'd2);
        @(negedge i_clk);
        queue_frame(24'h5A5A5A, 4'h4, 1'b0);
        queue_frame(24'h000001, 4'hF, 1'b1);
        queue_frame(24'h000002, 4'hF, 1'b0);
        queue_frame(24'h000003, 4'h0, 1'b1);
        wait_idle();
        write_reg(CFG_LEGACY_GAIN, 8'd4);
        @(negedge i_clk);
        queue_frame(24'hC00001, 4'hF, 1'b0);
        wait_idle();
        // period below two: every read schedules channel B next
        write_reg(CFG_PERIOD, 8'd0);
        write_reg(CFG_CHAN_A_CODE, 8'd0);
        write_reg(CFG_CHAN_B_CODE, 8'd7);
        write_reg(CFG_INTERLEAVE, 8'd1);
        @(negedge i_clk);
        repeat (4) queue_frame(random_count(), 4'hF, 1'b0);
        wait_idle();
        // short period shows settling samples after each channel B read
        write_reg(CFG_PERIOD, 8'd2);
        write_reg(CFG_CHAN_A_CODE, 8'd2);
        write_reg(CFG_CHAN_B_CODE, 8'd3);
        write_reg(CFG_INTERLEAVE, 8'd1);
        @(negedge i_clk);
        repeat (6) queue_frame(random_count(), 4'hF, 1'b0);

        while (rand_sent < 550) begin
            wait_idle();
            write_reg(CFG_LEGACY_GAIN, random_code_val());
            if ($urandom_range(1, 0)) write_reg(CFG_CHAN_A_CODE, random_code_val());
            if ($urandom_range(1, 0)) write_reg(CFG_CHAN_B_CODE, random_code_val());
            if ($urandom_range(1, 0)) write_reg(CFG_PERIOD, random_period());
            if ($urandom_range(2, 0) != 0)
                write_reg(CFG_INTERLEAVE, CFG_DATA_W'($urandom));
            if ($urandom_range(7, 0) == 0)
                write_reg(CFG_IDX_W'(CFG_PERIOD + 1 + $urandom_range(2, 0)),
                          CFG_DATA_W'($urandom));
            @(negedge i_clk);
            noisy     = ($urandom_range(2, 0) == 0);
            in_calm   = ($urandom_range(3, 0) == 0);
            out_calm  = ($urandom_range(3, 0) == 0);
            phase_len = $urandom_range(60, 15);
            repeat (phase_len)
                queue_frame(random_count(), random_tail(),
                            noisy && ($urandom_range(19, 0) == 0));
            rand_sent += phase_len;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("bridge_adc_frame_decoder verification clean");
        else
            $display("bridge_adc_frame_decoder verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("bridge_adc_frame_decoder verification failed");
        $finish;
    end

endmodule

### bridge_adc_frame_decoder.f
src/bafd_pkg.sv
src/bafd_sched.sv
src/bafd_decode.sv
src/bridge_adc_frame_decoder.sv
src/bafd_checker.sv
test/tb_bridge_adc_frame_decoder.sv
